### design/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg - shared types and constants of the b-spline basis evaluator
// Widths, opcodes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package bbe_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VAL_W      = FRAC_BITS + 1;
	localparam int IDX_W      = 6;
	localparam int MAX_KNOTS  = 64;
	localparam int MAX_DEGREE = 3;
	localparam int DEG_W      = 2;
	localparam int CNT_W      = 7;
	localparam int NUM_W      = VAL_W + FRAC_BITS;
	localparam int DEN_W      = VAL_W + 1;
	localparam int PROD_W     = VAL_W + NUM_W;
	localparam int SH_W       = PROD_W - FRAC_BITS;
	localparam int DCNT_W     = 6;

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] ONE_FIX = VAL_W'(1) << FRAC_BITS;

	// input opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// configuration register indexes
	localparam logic REG_DEGREE     = 1'b0;
	localparam logic REG_KNOT_COUNT = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LAST,
		S_ZERO,
		S_PK,
		S_CHK,
		S_SCAN,
		S_LRA,
		S_LRB,
		S_JST,
		S_DIVST,
		S_DIVW,
		S_MULR,
		S_MULL,
		S_UPD,
		S_BJ,
		S_EMIT,
		S_ERR
	} state_t;

	typedef enum logic [1:0] {
		A_IDX,
		A_LEFT,
		A_RIGHT
	} addr_sel_t;

	typedef struct packed {
		logic             knot_wr;
		logic             latch;
		addr_sel_t        addr_sel;
		logic [IDX_W-1:0] idx;
		logic             ld_kl;
		logic             span_ld;
		logic             cap_left;
		logic             cap_right;
		logic [DEG_W-1:0] jsel;
		logic [DEG_W-1:0] rsel;
		logic             clr_saved;
		logic             div_start;
		logic             ld_q;
		logic             mul_right;
		logic             mul_left;
		logic             upd_saved;
		logic             set_bj;
		logic             emit;
		logic             emit_err;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [DEG_W-1:0] p;
		logic [IDX_W-1:0] nu;
		logic             too_few;
		logic             u_lt_rd;
		logic             u_eq_kl;
		logic             u_gt_kl;
		logic             div_done;
	} dp_status_t;

endpackage
`default_nettype wire

### design/bbe_div.sv
// ----------------------------------------------------------------------------
// bbe_div - restoring divider, one quotient bit per cycle
// Ends each division with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bbe_pkg::NUM_W-1:0] num,
	input  wire logic [bbe_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic [bbe_pkg::NUM_W-1:0]      quot
);

	logic                        run_q;
	logic                        done_q;
	logic [bbe_pkg::DCNT_W-1:0]  cnt_q;
	logic [bbe_pkg::DEN_W-1:0]   den_q;
	logic [bbe_pkg::DEN_W-1:0]   rem_q;
	logic [bbe_pkg::NUM_W-1:0]   quo_q;
	logic [bbe_pkg::DEN_W:0]     trial;
	logic                        fits;

	// one trial subtraction
	assign trial = {rem_q, quo_q[bbe_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bbe_pkg::DCNT_W'(bbe_pkg::NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? bbe_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[bbe_pkg::DEN_W-1:0];
			quo_q <= {quo_q[bbe_pkg::NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

### design/bbe_datapath.sv
// ----------------------------------------------------------------------------
// bbe_datapath - knot store, configuration, recurrence arithmetic, outputs
// Acts on commands from the controller and reports compares back.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic                      wr_index,
	input  wire logic [bbe_pkg::CNT_W-1:0] wr_data,
	input  wire logic [bbe_pkg::IDX_W-1:0] knot_index,
	input  wire logic [bbe_pkg::VAL_W-1:0] knot_value,
	input  wire logic [bbe_pkg::VAL_W-1:0] param_value,
	input  wire bbe_pkg::ctrl_cmd_t        cmd,
	output bbe_pkg::dp_status_t            status,
	output logic                           valid,
	output logic [bbe_pkg::IDX_W-1:0]      span_index,
	output logic [bbe_pkg::IDX_W-1:0]      basis_index,
	output logic [bbe_pkg::VAL_W-1:0]      basis_value,
	output logic                           last,
	output logic                           error
);

	logic [bbe_pkg::VAL_W-1:0]  mem [bbe_pkg::MAX_KNOTS];
	logic [bbe_pkg::VAL_W-1:0]  rd_q;
	logic [bbe_pkg::IDX_W-1:0]  addr;

	logic [bbe_pkg::DEG_W-1:0]  degree_q;
	logic [bbe_pkg::CNT_W-1:0]  count_q;
	logic [bbe_pkg::DEG_W-1:0]  p_q;
	logic [bbe_pkg::IDX_W-1:0]  nu_q;
	logic                       too_few_q;
	logic [bbe_pkg::VAL_W-1:0]  u_q;
	logic [bbe_pkg::VAL_W-1:0]  kl_q;
	logic [bbe_pkg::IDX_W-1:0]  span_q;

	logic [bbe_pkg::VAL_W-1:0]  left_q  [1:bbe_pkg::MAX_DEGREE];
	logic [bbe_pkg::VAL_W-1:0]  right_q [1:bbe_pkg::MAX_DEGREE];
	logic [bbe_pkg::VAL_W-1:0]  basis_q [bbe_pkg::MAX_DEGREE+1];
	logic [bbe_pkg::VAL_W-1:0]  saved_q;
	logic [bbe_pkg::NUM_W-1:0]  q_q;
	logic                       den_zero_q;
	logic [bbe_pkg::PROD_W-1:0] prod_q;

	logic [bbe_pkg::DEG_W-1:0]  p_eff;
	logic [bbe_pkg::CNT_W-1:0]  n_eff;
	logic [bbe_pkg::CNT_W-1:0]  n_min;
	logic [bbe_pkg::DEG_W-1:0]  ridx;
	logic [bbe_pkg::DEG_W-1:0]  lidx;
	logic [bbe_pkg::VAL_W-1:0]  left_v;
	logic [bbe_pkg::VAL_W-1:0]  right_v;
	logic [bbe_pkg::DEN_W-1:0]  den;
	logic [bbe_pkg::NUM_W-1:0]  num;
	logic                       div_done;
	logic [bbe_pkg::NUM_W-1:0]  quot;
	logic [bbe_pkg::VAL_W-1:0]  mul_a;
	logic [bbe_pkg::SH_W-1:0]   prod_sh;
	logic [bbe_pkg::SH_W:0]     vsum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= bbe_pkg::DEG_W'(3);
			count_q  <= bbe_pkg::CNT_W'(8);
		end else if (wr_en) begin
			unique case (wr_index)
				bbe_pkg::REG_DEGREE:     degree_q <= wr_data[bbe_pkg::DEG_W-1:0];
				bbe_pkg::REG_KNOT_COUNT: count_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// effective degree and knot count
	assign p_eff = (degree_q == '0) ? bbe_pkg::DEG_W'(1) : degree_q;
	assign n_eff = (count_q > bbe_pkg::CNT_W'(bbe_pkg::MAX_KNOTS))
	             ? bbe_pkg::CNT_W'(bbe_pkg::MAX_KNOTS) : count_q;
	assign n_min = bbe_pkg::CNT_W'({p_eff, 1'b0}) + bbe_pkg::CNT_W'(2);

	// knot store address
	always_comb begin
		unique case (cmd.addr_sel)
			bbe_pkg::A_LEFT:  addr = span_q + bbe_pkg::IDX_W'(1)
			                       - bbe_pkg::IDX_W'(cmd.jsel);
			bbe_pkg::A_RIGHT: addr = span_q + bbe_pkg::IDX_W'(cmd.jsel);
			default:          addr = cmd.idx;
		endcase
	end

	// knot store
	always_ff @(posedge clk) begin
		if (cmd.knot_wr)
			mem[knot_index] <= knot_value;
		rd_q <= mem[addr];
	end

	// recurrence operand selection
	assign ridx    = cmd.rsel + bbe_pkg::DEG_W'(1);
	assign lidx    = cmd.jsel - cmd.rsel;
	assign right_v = right_q[ridx];
	assign left_v  = left_q[lidx];
	assign den     = bbe_pkg::DEN_W'(right_v) + bbe_pkg::DEN_W'(left_v);
	assign num     = {basis_q[cmd.rsel], {bbe_pkg::FRAC_BITS{1'b0}}};
	assign mul_a   = cmd.mul_left ? left_v : right_v;
	assign prod_sh = prod_q[bbe_pkg::PROD_W-1:bbe_pkg::FRAC_BITS];
	assign vsum    = (bbe_pkg::SH_W+1)'(saved_q) + {1'b0, prod_sh};

	bbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	// evaluation registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			u_q        <= param_value;
			p_q        <= p_eff;
			nu_q       <= bbe_pkg::IDX_W'(n_eff - bbe_pkg::CNT_W'(p_eff)
			                             - bbe_pkg::CNT_W'(2));
			too_few_q  <= n_eff < n_min;
			basis_q[0] <= bbe_pkg::ONE_FIX;
		end
		if (cmd.ld_kl)
			kl_q <= rd_q;
		if (cmd.span_ld)
			span_q <= cmd.idx;
		if (cmd.cap_left)
			left_q[cmd.jsel] <= (u_q > rd_q) ? u_q - rd_q : '0;
		if (cmd.cap_right)
			right_q[cmd.jsel] <= (rd_q > u_q) ? rd_q - u_q : '0;
		if (cmd.clr_saved)
			saved_q <= '0;
		if (cmd.div_start)
			den_zero_q <= den == '0;
		if (cmd.ld_q)
			q_q <= den_zero_q ? '0 : quot;
		if (cmd.mul_right || cmd.mul_left)
			prod_q <= bbe_pkg::PROD_W'(mul_a) * bbe_pkg::PROD_W'(q_q);
		// basis update uses the product with the right difference
		if (cmd.mul_left)
			basis_q[cmd.rsel] <= (vsum > (bbe_pkg::SH_W+1)'(bbe_pkg::VAL_MAX))
			                   ? bbe_pkg::VAL_MAX : vsum[bbe_pkg::VAL_W-1:0];
		if (cmd.upd_saved)
			saved_q <= (prod_sh > bbe_pkg::SH_W'(bbe_pkg::VAL_MAX))
			         ? bbe_pkg::VAL_MAX : prod_sh[bbe_pkg::VAL_W-1:0];
		if (cmd.set_bj)
			basis_q[cmd.jsel] <= saved_q;
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid <= 1'b0;
		else
			valid <= cmd.emit || cmd.emit_err;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			span_index  <= '0;
			basis_index <= '0;
			basis_value <= '0;
			last        <= 1'b1;
			error       <= 1'b1;
		end else if (cmd.emit) begin
			span_index  <= span_q;
			basis_index <= span_q - bbe_pkg::IDX_W'(p_q) + cmd.idx;
			basis_value <= basis_q[cmd.idx[bbe_pkg::DEG_W-1:0]];
			last        <= cmd.idx == bbe_pkg::IDX_W'(p_q);
			error       <= 1'b0;
		end
	end

	// status to the controller
	assign status.p        = p_q;
	assign status.nu       = nu_q;
	assign status.too_few  = too_few_q;
	assign status.u_lt_rd  = u_q < rd_q;
	assign status.u_eq_kl  = u_q == kl_q;
	assign status.u_gt_kl  = u_q > kl_q;
	assign status.div_done = div_done;

endmodule
`default_nettype wire

### design/bbe_ctrl.sv
// ----------------------------------------------------------------------------
// bbe_ctrl - sequencer of the span search and basis recurrence
// Walks range checks, span scan, difference loads, the triangular
// recurrence and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               opcode,
	input  wire bbe_pkg::dp_status_t status,
	output bbe_pkg::ctrl_cmd_t      cmd,
	output logic                    busy
);

	bbe_pkg::state_t            state_q, state_n;
	logic [bbe_pkg::IDX_W-1:0]  cnt_q, cnt_n;
	logic [bbe_pkg::DEG_W-1:0]  j_q, j_n;
	logic [bbe_pkg::DEG_W-1:0]  r_q, r_n;
	logic                       side_q, side_n;
	logic                       err_q, err_n;
	logic [bbe_pkg::IDX_W-1:0]  p_ext;

	assign p_ext = bbe_pkg::IDX_W'(status.p);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbe_pkg::S_IDLE;
			cnt_q   <= '0;
			j_q     <= '0;
			r_q     <= '0;
			side_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			j_q     <= j_n;
			r_q     <= r_n;
			side_q  <= side_n;
			err_q   <= err_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		j_n     = j_q;
		r_n     = r_q;
		side_n  = side_q;
		err_n   = err_q;
		cmd     = '0;
		cmd.addr_sel = bbe_pkg::A_IDX;
		cmd.jsel = j_q;
		cmd.rsel = r_q;
		unique case (state_q)
			bbe_pkg::S_IDLE: begin
				if (start && opcode == bbe_pkg::OP_WRITE)
					cmd.knot_wr = 1'b1;
				if (start && opcode == bbe_pkg::OP_EVAL) begin
					cmd.latch = 1'b1;
					state_n   = bbe_pkg::S_LAST;
				end
			end
			bbe_pkg::S_LAST: begin
				cmd.idx = status.nu + bbe_pkg::IDX_W'(1);
				state_n = status.too_few ? bbe_pkg::S_ERR : bbe_pkg::S_ZERO;
			end
			bbe_pkg::S_ZERO: begin
				cmd.ld_kl = 1'b1;
				cmd.idx   = '0;
				state_n   = bbe_pkg::S_PK;
			end
			bbe_pkg::S_PK: begin
				err_n   = status.u_lt_rd;
				cmd.idx = p_ext;
				state_n = bbe_pkg::S_CHK;
			end
			bbe_pkg::S_CHK: begin
				cmd.idx = status.nu;
				j_n     = bbe_pkg::DEG_W'(1);
				side_n  = 1'b0;
				if (status.u_eq_kl) begin
					// parameter at the last knot takes the last span
					cmd.span_ld = 1'b1;
					state_n     = bbe_pkg::S_LRA;
				end else if (status.u_gt_kl || err_q || status.u_lt_rd) begin
					state_n = bbe_pkg::S_ERR;
				end else begin
					cnt_n   = status.nu;
					state_n = bbe_pkg::S_SCAN;
				end
			end
			bbe_pkg::S_SCAN: begin
				// downward scan for the largest span whose knot is not above u
				if (!status.u_lt_rd || cnt_q == p_ext) begin
					cmd.idx     = cnt_q;
					cmd.span_ld = 1'b1;
					state_n     = bbe_pkg::S_LRA;
				end else begin
					cmd.idx = cnt_q - bbe_pkg::IDX_W'(1);
					cnt_n   = cnt_q - bbe_pkg::IDX_W'(1);
				end
			end
			bbe_pkg::S_LRA: begin
				cmd.addr_sel = side_q ? bbe_pkg::A_RIGHT : bbe_pkg::A_LEFT;
				state_n      = bbe_pkg::S_LRB;
			end
			bbe_pkg::S_LRB: begin
				cmd.cap_left  = !side_q;
				cmd.cap_right = side_q;
				if (!side_q) begin
					side_n  = 1'b1;
					state_n = bbe_pkg::S_LRA;
				end else begin
					side_n = 1'b0;
					if (j_q == status.p) begin
						j_n     = bbe_pkg::DEG_W'(1);
						state_n = bbe_pkg::S_JST;
					end else begin
						j_n     = j_q + bbe_pkg::DEG_W'(1);
						state_n = bbe_pkg::S_LRA;
					end
				end
			end
			bbe_pkg::S_JST: begin
				cmd.clr_saved = 1'b1;
				r_n           = '0;
				state_n       = bbe_pkg::S_DIVST;
			end
			bbe_pkg::S_DIVST: begin
				cmd.div_start = 1'b1;
				state_n       = bbe_pkg::S_DIVW;
			end
			bbe_pkg::S_DIVW: begin
				if (status.div_done) begin
					cmd.ld_q = 1'b1;
					state_n  = bbe_pkg::S_MULR;
				end
			end
			bbe_pkg::S_MULR: begin
				cmd.mul_right = 1'b1;
				state_n       = bbe_pkg::S_MULL;
			end
			bbe_pkg::S_MULL: begin
				cmd.mul_left = 1'b1;
				state_n      = bbe_pkg::S_UPD;
			end
			bbe_pkg::S_UPD: begin
				cmd.upd_saved = 1'b1;
				if (r_q == j_q - bbe_pkg::DEG_W'(1)) begin
					state_n = bbe_pkg::S_BJ;
				end else begin
					r_n     = r_q + bbe_pkg::DEG_W'(1);
					state_n = bbe_pkg::S_DIVST;
				end
			end
			bbe_pkg::S_BJ: begin
				cmd.set_bj = 1'b1;
				if (j_q == status.p) begin
					cnt_n   = '0;
					state_n = bbe_pkg::S_EMIT;
				end else begin
					j_n     = j_q + bbe_pkg::DEG_W'(1);
					state_n = bbe_pkg::S_JST;
				end
			end
			bbe_pkg::S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.idx  = cnt_q;
				if (cnt_q == p_ext)
					state_n = bbe_pkg::S_IDLE;
				else
					cnt_n = cnt_q + bbe_pkg::IDX_W'(1);
			end
			bbe_pkg::S_ERR: begin
				cmd.emit_err = 1'b1;
				state_n      = bbe_pkg::S_IDLE;
			end
			default: state_n = bbe_pkg::S_IDLE;
		endcase
	end

	assign busy = state_q != bbe_pkg::S_IDLE;

endmodule
`default_nettype wire

### design/bspline_basis_evaluator.sv
// ----------------------------------------------------------------------------
// bspline_basis_evaluator - knot span search and b-spline basis values
// Usage:
//   An item is taken when start is high and busy is low. Opcode write
//   stores knot_value at knot_index and gives no result; the block stays
//   free for the next item in the following cycle.
//   Opcode evaluate checks param_value against the knot range, finds its
//   span by a downward scan of the knot store (one knot read a cycle) and
//   runs the triangular recurrence through one shared restoring divider
//   and one multiplier used twice per term. Then p+1 results follow on
//   consecutive cycles, each marked by valid for one cycle, with last on
//   the final one. A parameter outside the range gives one result with
//   error and last set. Busy falls as the final result shows, so a new
//   item may be taken in that cycle. The receiver cannot stall.
//   Configuration writes (wr_en, wr_index, wr_data) are taken in any cycle
//   and belong to idle periods. Reset sets degree 3 and knot count 8 and
//   idles the block; the knot store is not cleared and must be loaded
//   before use.
// ----------------------------------------------------------------------------
`default_nettype none
module bspline_basis_evaluator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic                      wr_index,
	input  wire logic [bbe_pkg::CNT_W-1:0] wr_data,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      opcode,
	input  wire logic [bbe_pkg::IDX_W-1:0] knot_index,
	input  wire logic [bbe_pkg::VAL_W-1:0] knot_value,
	input  wire logic [bbe_pkg::VAL_W-1:0] param_value,
	output logic                           valid,
	output logic [bbe_pkg::IDX_W-1:0]      span_index,
	output logic [bbe_pkg::IDX_W-1:0]      basis_index,
	output logic [bbe_pkg::VAL_W-1:0]      basis_value,
	output logic                           last,
	output logic                           error
);

	bbe_pkg::ctrl_cmd_t  cmd;
	bbe_pkg::dp_status_t status;

	// controller
	bbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	bbe_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.knot_index  (knot_index),
		.knot_value  (knot_value),
		.param_value (param_value),
		.cmd         (cmd),
		.status      (status),
		.valid       (valid),
		.span_index  (span_index),
		.basis_index (basis_index),
		.basis_value (basis_value),
		.last        (last),
		.error       (error)
	);

endmodule
`default_nettype wire

### design/bbe_checker.sv
// ----------------------------------------------------------------------------
// bbe_checker - port level checks of the basis evaluator
// Grouping, busy, error shape and timing of results; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      valid,
	input wire logic [bbe_pkg::IDX_W-1:0] span_index,
	input wire logic [bbe_pkg::VAL_W-1:0] basis_value,
	input wire logic                      last,
	input wire logic                      error
);

	// results of one evaluation come on consecutive cycles
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("result burst broken");

	// more results pending means the block is still busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("idle with results pending");

	// an error result stands alone and carries zeros
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error |-> last && basis_value == '0 && span_index == '0)
		else $error("malformed error result");

	// an item taken while idle never has a result in the next cycle
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !valid)
		else $error("result too early");

endmodule

bind bspline_basis_evaluator bbe_checker u_bbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.valid       (valid),
	.span_index  (span_index),
	.basis_value (basis_value),
	.last        (last),
	.error       (error)
);
`default_nettype wire
